### rtl/ife_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_pkg
// Shared types and constants for the sensor frame field extractor.
// ----------------------------------------------------------------------------
package ife_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFA;
  localparam logic [7:0] BUSID_BYTE = 8'hFF;
  localparam logic [7:0] MSGID_BYTE = 8'h36;
  localparam logic [7:0] LEN_ANGLES = 8'h2D;
  localparam logic [7:0] LEN_QUAT   = 8'h31;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int QIDX_W  = 4;
  localparam int POS_W   = 6;
  localparam int PART_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [POS_W-1:0] TAG_BYTES = 6'd3;

  localparam logic [POS_W-1:0] O_END_ANG   = 6'd15;
  localparam logic [POS_W-1:0] O_END_QUAT  = 6'd19;
  localparam logic [POS_W-1:0] A_START_ANG = 6'd18;
  localparam logic [POS_W-1:0] A_START_QT  = 6'd22;
  localparam logic [POS_W-1:0] A_END_ANG   = 6'd30;
  localparam logic [POS_W-1:0] A_END_QUAT  = 6'd34;
  localparam logic [POS_W-1:0] G_START_ANG = 6'd33;
  localparam logic [POS_W-1:0] G_START_QT  = 6'd37;
  localparam logic [POS_W-1:0] LEN_ANG_POS = 6'd45;
  localparam logic [POS_W-1:0] LEN_QT_POS  = 6'd49;

  localparam logic [QIDX_W-1:0] NQ_ANG  = 4'd3;
  localparam logic [QIDX_W-1:0] NQ_QUAT = 4'd4;
  localparam logic [QIDX_W-1:0] ACC_GYRO_GAP = 4'd3;

  typedef enum logic [2:0] {
    ST_HUNT0 = 3'd0,
    ST_HUNT1 = 3'd1,
    ST_HUNT2 = 3'd2,
    ST_HUNT3 = 3'd3,
    ST_DATA  = 3'd4
  } ife_stage_t;

  typedef struct packed {
    logic                    valid;
    logic [WORD_W-1:0]       sample_word;
    logic [QIDX_W-1:0]       quantity_index;
    logic                    last_of_frame;
  } ife_result_t;

endpackage

### rtl/ife_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ife_parse
// Header hunt, payload position tracking and big-endian word assembly.
// ----------------------------------------------------------------------------
module ife_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [ife_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          frame_format,
  output ife_pkg::ife_result_t          res
);
  import ife_pkg::*;

  ife_stage_t          stage_r, stage_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [PART_W-1:0]   part_r, part_nxt;

  logic [POS_W-1:0]    o_end, a_start, a_end, g_start, len, start, rel, pos_inc;
  logic [QIDX_W-1:0]   nq, base;
  logic [BYTE_W-1:0]   exp_byte;
  logic                is_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HUNT0;
      pos_r   <= '0;
      part_r  <= '0;
    end else if (step_en) begin
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
      part_r  <= part_nxt;
    end
  end

  always_comb begin
    nq      = frame_format ? NQ_QUAT : NQ_ANG;
    o_end   = frame_format ? O_END_QUAT : O_END_ANG;
    a_start = frame_format ? A_START_QT : A_START_ANG;
    a_end   = frame_format ? A_END_QUAT : A_END_ANG;
    g_start = frame_format ? G_START_QT : G_START_ANG;
    len     = frame_format ? LEN_QT_POS : LEN_ANG_POS;
    pos_inc = pos_r + 6'd1;

    is_data = 1'b0;
    start   = '0;
    base    = '0;
    if (pos_r >= TAG_BYTES && pos_r < o_end) begin
      is_data = 1'b1;
      start   = TAG_BYTES;
      base    = '0;
    end else if (pos_r >= a_start && pos_r < a_end) begin
      is_data = 1'b1;
      start   = a_start;
      base    = nq;
    end else if (pos_r >= g_start) begin
      is_data = 1'b1;
      start   = g_start;
      base    = nq + ACC_GYRO_GAP;
    end
    rel = pos_r - start;

    case (stage_r)
      ST_HUNT1: exp_byte = BUSID_BYTE;
      ST_HUNT2: exp_byte = MSGID_BYTE;
      ST_HUNT3: exp_byte = frame_format ? LEN_QUAT : LEN_ANGLES;
      default:  exp_byte = SYNC_BYTE;
    endcase

    stage_nxt              = stage_r;
    pos_nxt                = pos_r;
    part_nxt               = part_r;
    res.valid              = 1'b0;
    res.sample_word        = {part_r, rx_byte};
    res.quantity_index     = base + rel[POS_W-1:2];
    res.last_of_frame      = (pos_inc == len);

    case (stage_r)
      ST_DATA: begin
        if (pos_r >= len) begin
          stage_nxt = ST_HUNT0;
          pos_nxt   = '0;
        end else begin
          if (pos_inc >= len) begin
            stage_nxt = ST_HUNT0;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc;
          end
          if (is_data) begin
            case (rel[1:0])
              2'd0:    part_nxt = {16'd0, rx_byte};
              2'd3: begin
                part_nxt  = '0;
                res.valid = 1'b1;
              end
              default: part_nxt = {part_r[PART_W-BYTE_W-1:0], rx_byte};
            endcase
          end
        end
      end
      default: begin
        if (rx_byte == exp_byte) begin
          case (stage_r)
            ST_HUNT1: stage_nxt = ST_HUNT2;
            ST_HUNT2: stage_nxt = ST_HUNT3;
            ST_HUNT3: begin
              stage_nxt = ST_DATA;
              pos_nxt   = '0;
              part_nxt  = '0;
            end
            default:  stage_nxt = ST_HUNT1;
          endcase
        end else begin
          stage_nxt = (rx_byte == SYNC_BYTE) ? ST_HUNT1 : ST_HUNT0;
        end
      end
    endcase
  end

endmodule

### rtl/imu_frame_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_field_extractor
// Parses the sensor's serial byte stream and emits the frame's data words.
// ----------------------------------------------------------------------------
// Each item on the in_ stream is one received byte. The block hunts for the
// header FA FF 36 LEN, skips the tag in front of each group and sends every
// assembled 32-bit word on the out_ stream with its quantity index; tlast
// marks the gyro z word that closes a frame. Header and tag bytes give no
// item. The cfg_ channel sets the frame format (0 angles, 1 quaternion) and
// is always ready; write it only while the block is idle.
// A byte passes an input register and then the parser, whose result lands
// in the output register, from which the word is offered on the out_
// stream. One byte is taken in every cycle while the receiver keeps up.
// When out_tready is low the output register holds its word, the input
// register fills and in_tready drops until the result is taken.
// Reset clears the hunt, the register (angle format) and both stages.
// ----------------------------------------------------------------------------
module imu_frame_field_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ife_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ife_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] sample_word,
                                                         // [35:32] quantity_index
  output logic                               out_tlast,  // last_of_frame
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);
  import ife_pkg::*;

  logic                 in_vld_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic                 fmt_r;
  logic                 out_vld_r;
  logic [WORD_W-1:0]    out_word_r;
  logic [QIDX_W-1:0]    out_qidx_r;
  logic                 out_last_r;
  logic                 step;
  ife_result_t          res;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fmt_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fmt_r <= cfg_data;
      end
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (step) begin
        out_vld_r <= res.valid;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (step && res.valid) begin
      out_word_r <= res.sample_word;
      out_qidx_r <= res.quantity_index;
      out_last_r <= res.last_of_frame;
    end
  end

  ife_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step),
    .rx_byte      (in_byte_r),
    .frame_format (fmt_r),
    .res          (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W - QIDX_W){1'b0}}, out_qidx_r, out_word_r};
  assign out_tlast  = out_last_r;

endmodule

### test/tb_imu_frame_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_frame_field_extractor
// Self-checking regression for the sensor frame field extractor.
// ----------------------------------------------------------------------------
// Bytes are pushed into the in_ stream and every accepted byte is run through
// a local parser model that tracks the header hunt, the payload position and
// the partly assembled word. Each word that the model produces is queued and
// compared, field by field, with the items taken from the out_ stream. A
// short table of hand-picked bytes comes first, then random phases in both
// frame formats made mostly of whole frames with random content, mixed with
// broken headers and noise. Frames are left unfinished at phase ends so that
// a format change falls in the middle of a frame, including one beyond the
// end of the shorter frame. Both sides stall at random, and once the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_imu_frame_field_extractor;
  import ife_pkg::*;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          PHASE_BYTES  = 45;
  localparam int          SETTLE_WAIT  = 8;
  localparam int          PRINT_CAP    = 50;
  localparam logic        FMT_ANGLES   = 1'b0;
  localparam logic        FMT_QUAT     = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [QIDX_W-1:0] idx;
    logic              last;
  } sample_t;

  typedef enum logic {ROW_BYTE, ROW_FORMAT} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    logic       typed;
    sample_t    want;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data   = 1'b0;

  // Parser model state.
  ife_stage_t        hunt_stage = ST_HUNT0;
  logic [POS_W-1:0]  pay_pos    = '0;
  logic [PART_W-1:0] part_word  = '0;
  logic              cur_fmt    = FMT_ANGLES;

  sample_t     words_due[$];
  dir_row_t    dir_tab[$];
  int          errors        = 0;
  int          words_checked = 0;
  int          frames_seen   = 0;
  int          bytes_sent    = 0;
  int          format_writes = 0;
  int          stall_count   = 0;
  int          snd_idle_pct  = 21;
  int          rcv_idle_pct  = 81;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int          hold_left     = 0;

  imu_frame_field_extractor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] sample_word, [35:32] quantity_index
    .out_tlast  (out_tlast),  // last_of_frame
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Advances the parser model by one byte; returns 1 when a word completes.
  function automatic bit parse_byte(input logic [7:0] b, output sample_t res);
    ife_stage_t st;
    logic [7:0] want;
    int         nq, o_end, a_start, a_end, g_start, flen, pos, start, base, rel;
    bit         is_data;
    res     = '0;
    is_data = 1'b0;
    start   = 0;
    base    = 0;
    if (hunt_stage != ST_DATA) begin
      st = (hunt_stage > ST_HUNT3) ? ST_HUNT0 : hunt_stage;
      case (st)
        ST_HUNT0: want = SYNC_BYTE;
        ST_HUNT1: want = BUSID_BYTE;
        ST_HUNT2: want = MSGID_BYTE;
        default:  want = (cur_fmt == FMT_QUAT) ? LEN_QUAT : LEN_ANGLES;
      endcase
      if (b == want) begin
        if (st == ST_HUNT3) begin
          hunt_stage = ST_DATA;
          pay_pos    = '0;
          part_word  = '0;
        end else begin
          hunt_stage = ife_stage_t'(st + 3'd1);
        end
      end else begin
        hunt_stage = (b == SYNC_BYTE) ? ST_HUNT1 : ST_HUNT0;
      end
      return 1'b0;
    end
    nq      = (cur_fmt == FMT_QUAT) ? 4 : 3;
    o_end   = 3 + 4 * nq;
    a_start = o_end + 3;
    a_end   = a_start + 12;
    g_start = a_end + 3;
    flen    = g_start + 12;
    pos     = int'(pay_pos);
    if (pos >= flen) begin
      hunt_stage = ST_HUNT0;
      pay_pos    = '0;
      return 1'b0;
    end
    if (pos >= 3 && pos < o_end) begin
      is_data = 1'b1;
      start   = 3;
      base    = 0;
    end else if (pos >= a_start && pos < a_end) begin
      is_data = 1'b1;
      start   = a_start;
      base    = nq;
    end else if (pos >= g_start) begin
      is_data = 1'b1;
      start   = g_start;
      base    = nq + 3;
    end
    if (pos + 1 >= flen) begin
      hunt_stage = ST_HUNT0;
      pay_pos    = '0;
    end else begin
      pay_pos = POS_W'(pos + 1);
    end
    if (!is_data) return 1'b0;
    rel = pos - start;
    case (rel % 4)
      0: begin
        part_word = {16'h0000, b};
        return 1'b0;
      end
      1, 2: begin
        part_word = {part_word[15:0], b};
        return 1'b0;
      end
      default: begin
        res.word  = {part_word, b};
        res.idx   = QIDX_W'(base + rel / 4);
        res.last  = (pos + 1 == flen);
        part_word = '0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic dir_row_t row(input row_kind_t kind, input logic [7:0] val,
                                   input logic typed, input logic [31:0] word,
                                   input logic [3:0] idx, input logic last);
    dir_row_t r;
    r.kind      = kind;
    r.val       = val;
    r.typed     = typed;
    r.want.word = word;
    r.want.idx  = idx;
    r.want.last = last;
    return r;
  endfunction

  // Payload bytes lean towards the header values, which must pass as data.
  function automatic logic [7:0] data_byte();
    case ($urandom_range(7))
      0: return SYNC_BYTE;
      1: return BUSID_BYTE;
      2: return MSGID_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < PRINT_CAP)
      $display("%0t ns mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit use_typed, input sample_t typed_word);
    sample_t res;
    bit      has;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(negedge clk);
    while (!in_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    has = parse_byte(b, res);
    if (use_typed) words_due.push_back(typed_word);
    else if (has) words_due.push_back(res);
    bytes_sent++;
    @(posedge clk);
  endtask

  // Lets every expected word arrive, then waits on so that bytes that give
  // no word also pass through and the block is idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_format(input logic fmt);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    cur_fmt = fmt;
    format_writes++;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] len_byte, input int n_payload);
    send_byte(SYNC_BYTE, 1'b0, '0);
    send_byte(BUSID_BYTE, 1'b0, '0);
    send_byte(MSGID_BYTE, 1'b0, '0);
    send_byte(len_byte, 1'b0, '0);
    for (int i = 0; i < n_payload; i++) send_byte(data_byte(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(negedge clk) begin
    sample_t want;
    if (out_tvalid && out_tready) begin
      if (words_due.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = words_due.pop_front();
        if (out_tdata[WORD_W-1:0] != want.word)
          report_mismatch("sample_word", out_tdata[WORD_W-1:0], want.word);
        if (out_tdata[WORD_W+QIDX_W-1:WORD_W] != want.idx)
          report_mismatch("quantity_index", out_tdata[WORD_W+QIDX_W-1:WORD_W], want.idx);
        if (out_tlast != want.last)
          report_mismatch("last_of_frame", out_tlast, want.last);
        if (out_tdata[OUT_TDATA_W-1:WORD_W+QIDX_W] != '0)
          report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:WORD_W+QIDX_W], 0);
        words_checked++;
        if (want.last) frames_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("imu_frame_field_extractor regression: fail");
      $finish;
    end
  end

  initial begin
    int   phase_start, pick, cut, flen;
    logic fmt;
    logic [7:0] hdr[3];
    hdr[0] = SYNC_BYTE;
    hdr[1] = BUSID_BYTE;
    hdr[2] = MSGID_BYTE;

    // Angle format from reset: a repeated sync byte, the header, a tag holding
    // header values, then all-ones, all-zeros and header bytes as data.
    dir_tab.push_back(row(ROW_BYTE, SYNC_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, SYNC_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, BUSID_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, MSGID_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, LEN_ANGLES, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h00, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, SYNC_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, BUSID_BYTE, 1'b0, '0, '0, 1'b0));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row(ROW_BYTE, 8'hFF, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 4'd0, 1'b0));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row(ROW_BYTE, 8'h00, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h00, 1'b1, 32'h0000_0000, 4'd1, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, SYNC_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, BUSID_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, MSGID_BYTE, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, LEN_ANGLES, 1'b0, '0, '0, 1'b0));
    // Switch to quaternion format in the middle of the frame.
    dir_tab.push_back(row(ROW_FORMAT, {7'd0, FMT_QUAT}, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h12, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h34, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h56, 1'b0, '0, '0, 1'b0));
    dir_tab.push_back(row(ROW_BYTE, 8'h78, 1'b0, '0, '0, 1'b0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_FORMAT) set_format(dir_tab[i].val[0]);
      else send_byte(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      fmt = ph[0];
      set_format(fmt);
      case (ph / 2)
        0: begin
          snd_idle_pct = 21;
          rcv_idle_pct = 81;
        end
        1: begin
          snd_idle_pct = 81;
          rcv_idle_pct = 21;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (ph == 4) hold_asked++;
      flen        = (fmt == FMT_QUAT) ? int'(LEN_QUAT) : int'(LEN_ANGLES);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame((fmt == FMT_QUAT) ? LEN_QUAT : LEN_ANGLES, flen + 1);
        end else if (pick < 80) begin
          cut = $urandom_range(1, 3);
          for (int i = 0; i < cut; i++) send_byte(hdr[i], 1'b0, '0);
          send_byte(8'($urandom), 1'b0, '0);
        end else if (pick < 88) begin
          send_frame((fmt == FMT_QUAT) ? LEN_ANGLES : LEN_QUAT, $urandom_range(1, 12));
        end else begin
          cut = $urandom_range(1, 8);
          for (int i = 0; i < cut; i++) send_byte(8'($urandom), 1'b0, '0);
        end
      end
      // Leave a frame open so that the next format takes over mid-frame; the
      // first quaternion phase stops past the end of an angle frame.
      cut = (ph == 1) ? $urandom_range(46, 48) : $urandom_range(0, flen - 1);
      send_frame((fmt == FMT_QUAT) ? LEN_QUAT : LEN_ANGLES, cut);
    end

    settle();
    $display("covered %0d bytes, %0d words checked, %0d complete frames, %0d format writes",
             bytes_sent, words_checked, frames_seen, format_writes);
    $display("stalls on both sides, a %0d-cycle receiver hold-off, format changes mid-frame",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("imu_frame_field_extractor regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("imu_frame_field_extractor regression: fail");
    end
    $finish;
  end

endmodule
